### hdl/i2c_crc8_framed_transfer_assert.svh
// Assertion macros shared by the modules of the I2C CRC-8 transfer sequencer.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef I2C_CRC8_FRAMED_TRANSFER_ASSERT_SVH
`define I2C_CRC8_FRAMED_TRANSFER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IC8_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IC8_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/ic8_pkg.sv
// Package of the I2C CRC-8 transfer sequencer: codes, control and status structs, CRC function.
// Used by ic8_ctrl, ic8_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package ic8_pkg;

	localparam int MAX_READ_LEN = 16;
	localparam int BUF_AW = (MAX_READ_LEN > 1) ? $clog2(MAX_READ_LEN) : 1;
	localparam int KW = BUF_AW + 1;

	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] CRC_MSB = 8'h80;

	typedef enum logic [2:0] {
		CMD_WR_BEGIN = 3'd0,
		CMD_WR_BYTE  = 3'd1,
		CMD_RD_BEGIN = 3'd2,
		CMD_RX_BYTE  = 3'd3,
		CMD_NACK     = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ACT_START     = 3'd0,
		ACT_SEND      = 3'd1,
		ACT_RECV_ACK  = 3'd2,
		ACT_RECV_NACK = 3'd3,
		ACT_STOP      = 3'd4,
		ACT_DATA      = 3'd5,
		ACT_STATUS    = 3'd6
	} act_t;

	typedef enum logic [1:0] {
		STS_OK   = 2'd0,
		STS_NACK = 2'd1,
		STS_CRC  = 2'd2,
		STS_REJ  = 2'd3
	} sts_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_WR   = 2'd1,
		MODE_RD   = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		VAL_ZERO  = 3'd0,
		VAL_WADDR = 3'd1,
		VAL_RADDR = 3'd2,
		VAL_REG   = 3'd3,
		VAL_DATA  = 3'd4,
		VAL_CRC   = 3'd5,
		VAL_RBUF  = 3'd6
	} val_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_START,
		ST_SEND_WA,
		ST_SEND_REG,
		ST_RESTART,
		ST_SEND_RA,
		ST_RECV,
		ST_WDATA,
		ST_WCRC,
		ST_STOP,
		ST_DATA,
		ST_STAT_OK,
		ST_STAT_NACK,
		ST_STAT_CRC,
		ST_STAT_REJ
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load;
		logic     set_wr;
		logic     set_rd;
		logic     go_idle;
		logic     seed_waddr;
		logic     seed_reg;
		logic     seed_raddr;
		logic     wr_byte;
		logic     rx_byte;
		logic     rd_first;
		logic     rd_next;
		val_sel_t val_sel;
	} ic8_ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] cmd;
		mode_t      mode;
		logic       crc_on;
		logic       len_ok;
		logic       lastb;
		logic       cnt_zero;
		logic       more_recv;
		logic       recv_nack;
		logic       crc_bad;
		logic       data_last;
	} ic8_stat_t;

	// CRC-8, polynomial 0x07, MSB first, no reflection, no final xor.
	function automatic logic [7:0] crc8(input logic [7:0] seed, input logic [7:0] b);
		logic [7:0] c;
		c = seed ^ b;
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_MSB) != 8'h00) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

### hdl/i2c_crc8_framed_transfer.sv
// An accepted item is decoded first, then gives one result beat per cycle, 0 to 18 results
// in all; busy stays high through its last beat, and only then is the next item taken.
// The controller emits every beat itself; the receiver cannot stall it.
// Reset (arst_n low, asynchronous) returns to idle with crc_on = 1 and no transfer open;
// the read buffer is not cleared, as every entry is written before it is read.
// Top level of the I2C CRC-8 transfer sequencer; depends on ic8_pkg, ic8_ctrl, ic8_datapath.
`timescale 1ns / 1ps

module i2c_crc8_framed_transfer import ic8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// Command channel: a beat is taken when start is high and busy is low.
	input  logic       start,
	output logic       busy,
	input  logic [2:0] cmd,
	input  logic [6:0] dev_addr,
	input  logic [7:0] reg_addr,
	input  logic [7:0] data,
	input  logic [4:0] read_len,
	input  logic       last_byte,
	// Configuration channel for the crc_on register.
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	// Result channel: one beat per cycle while strobe is high.
	output logic       strobe,
	output logic [2:0] action,
	output logic [7:0] value,
	output logic [1:0] status,
	output logic       last
);

	// The controller owns sequencing; the datapath holds the item fields, the transfer
	// state (mode, byte count, CRC seed, pair byte, CRC error flag) and the read buffer.
	ic8_ctl_t  ctl;
	ic8_stat_t stat;
	act_t      act_w;
	sts_t      sts_w;

	// The register may only change while no item is being worked on, so writes are
	// taken while the controller is idle.
	assign cfg_ready = !busy;

	ic8_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy),
		.strobe (strobe),
		.action (act_w),
		.status (sts_w),
		.last   (last)
	);

	ic8_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.dev_addr  (dev_addr),
		.reg_addr  (reg_addr),
		.data      (data),
		.read_len  (read_len),
		.last_byte (last_byte),
		.ctl       (ctl),
		.stat      (stat),
		.value     (value)
	);

	assign action = act_w;
	assign status = sts_w;

endmodule

### hdl/ic8_datapath.sv
// Datapath of the I2C CRC-8 transfer sequencer: item registers, transfer state, CRC unit
// and read buffer. Depends on ic8_pkg; driven by ic8_ctrl.
`timescale 1ns / 1ps

module ic8_datapath import ic8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_data,
	input  logic [2:0] cmd,
	input  logic [6:0] dev_addr,
	input  logic [7:0] reg_addr,
	input  logic [7:0] data,
	input  logic [4:0] read_len,
	input  logic       last_byte,
	input  ic8_ctl_t   ctl,
	output ic8_stat_t  stat,
	output logic [7:0] value
);

	// Latched item fields.
	logic [2:0] cmd_q;
	logic [6:0] dev_q;
	logic [7:0] reg_q;
	logic [7:0] data_q;
	logic [4:0] rlen_q;
	logic       lastb_q;

	// Transfer state.
	logic          crc_on_q;
	mode_t         mode_q;
	logic [7:0]    seed_q;
	logic [5:0]    bc_q;
	logic [4:0]    xfer_q;
	logic [7:0]    pair_q;
	logic          crc_bad_q;
	logic [7:0]    crc_val_q;
	logic [KW-1:0] k_q;
	logic [7:0]    rdata_q;

	logic [7:0] rbuf [MAX_READ_LEN];

	logic [7:0]        waddr, raddr;
	logic [5:0]        cnt_next, total, wr_idx;
	logic [6:0]        bc_inc;
	logic [7:0]        crc_seed_in, crc_byte_in, crc_out;
	logic              buf_we;
	logic [KW-1:0]     k_inc;
	logic [BUF_AW-1:0] rd_addr;

	assign waddr = {dev_q, 1'b0};
	assign raddr = {dev_q, 1'b1};
	assign cnt_next = (bc_q == 6'd63) ? bc_q : bc_q + 6'd1;
	assign bc_inc = {1'b0, bc_q} + 7'd1;
	assign total = crc_on_q ? {xfer_q, 1'b0} : {1'b0, xfer_q};
	assign wr_idx = crc_on_q ? {1'b0, bc_q[5:1]} : bc_q;
	assign buf_we = ctl.rx_byte && (!crc_on_q || !bc_q[0]) && (wr_idx < 6'(MAX_READ_LEN));
	assign k_inc = k_q + 1'b1;
	assign rd_addr = ctl.rd_first ? '0 : k_inc[BUF_AW-1:0];

	// One CRC unit shared by the seed steps, the write CRC and the read check.
	always_comb begin
		crc_seed_in = 8'h00;
		crc_byte_in = data_q;
		if (ctl.seed_waddr) begin
			crc_byte_in = waddr;
		end else if (ctl.seed_reg) begin
			crc_seed_in = seed_q;
			crc_byte_in = reg_q;
		end else if (ctl.seed_raddr) begin
			crc_byte_in = raddr;
		end else if (ctl.wr_byte) begin
			crc_seed_in = (bc_q == 6'd0) ? seed_q : 8'h00;
		end else begin
			crc_seed_in = (bc_q == 6'd1) ? seed_q : 8'h00;
			crc_byte_in = pair_q;
		end
	end
	assign crc_out = crc8(crc_seed_in, crc_byte_in);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
			dev_q <= dev_addr;
			reg_q <= reg_addr;
			data_q <= data;
			rlen_q <= read_len;
			lastb_q <= last_byte;
		end
		if (ctl.wr_byte) begin
			crc_val_q <= crc_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_on_q <= 1'b1;
			mode_q <= MODE_IDLE;
			seed_q <= 8'h00;
			bc_q <= 6'd0;
			xfer_q <= 5'd0;
			pair_q <= 8'h00;
			crc_bad_q <= 1'b0;
			k_q <= '0;
		end else begin
			if (cfg_we) begin
				crc_on_q <= cfg_data;
			end
			if (ctl.set_wr) begin
				mode_q <= MODE_WR;
				bc_q <= 6'd0;
			end
			if (ctl.set_rd) begin
				mode_q <= MODE_RD;
				xfer_q <= rlen_q;
				bc_q <= 6'd0;
				crc_bad_q <= 1'b0;
				pair_q <= 8'h00;
			end
			if (ctl.go_idle) begin
				mode_q <= MODE_IDLE;
			end
			if (ctl.seed_waddr || ctl.seed_reg || ctl.seed_raddr) begin
				seed_q <= crc_out;
			end
			if (ctl.wr_byte) begin
				bc_q <= cnt_next;
			end
			if (ctl.rx_byte) begin
				bc_q <= cnt_next;
				if (crc_on_q && !bc_q[0]) begin
					pair_q <= data_q;
				end
				if (crc_on_q && bc_q[0] && (crc_out != data_q)) begin
					crc_bad_q <= 1'b1;
				end
			end
			if (ctl.rd_first) begin
				k_q <= '0;
			end else if (ctl.rd_next) begin
				k_q <= k_inc;
			end
		end
	end

	// Read buffer: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (buf_we) begin
			rbuf[wr_idx[BUF_AW-1:0]] <= data_q;
		end
		if (ctl.rd_first || ctl.rd_next) begin
			rdata_q <= rbuf[rd_addr];
		end
	end

	always_comb begin
		case (ctl.val_sel)
			VAL_WADDR: value = waddr;
			VAL_RADDR: value = raddr;
			VAL_REG:   value = reg_q;
			VAL_DATA:  value = data_q;
			VAL_CRC:   value = crc_val_q;
			VAL_RBUF:  value = rdata_q;
			default:   value = 8'h00;
		endcase
	end

	assign stat.cmd = cmd_q;
	assign stat.mode = mode_q;
	assign stat.crc_on = crc_on_q;
	assign stat.len_ok = (rlen_q != 5'd0) && ({1'b0, rlen_q} <= 6'(MAX_READ_LEN));
	assign stat.lastb = lastb_q;
	assign stat.cnt_zero = (bc_q == 6'd0);
	assign stat.more_recv = (cnt_next < total);
	assign stat.recv_nack = (bc_inc >= {1'b0, total});
	assign stat.crc_bad = crc_bad_q;
	assign stat.data_last = ((6'(k_q) + 6'd1) == {1'b0, xfer_q});

endmodule

### hdl/ic8_ctrl.sv
// Controller of the I2C CRC-8 transfer sequencer: decodes each item and steps through
// the result beats. Depends on ic8_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "i2c_crc8_framed_transfer_assert.svh"

module ic8_ctrl import ic8_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  ic8_stat_t stat,
	output ic8_ctl_t  ctl,
	output logic      busy,
	output logic      strobe,
	output act_t      action,
	output sts_t      status,
	output logic      last
);

	state_t state_q, state_d;
	logic   nack_ignored;

	assign nack_ignored = stat.crc_on &&
		((stat.mode == MODE_RD) || ((stat.mode == MODE_WR) && stat.cnt_zero));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl = '0;
		ctl.val_sel = VAL_ZERO;
		strobe = 1'b0;
		action = ACT_START;
		status = STS_OK;
		last = 1'b0;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_IDLE;
				case (stat.cmd)
					CMD_WR_BEGIN: begin
						if (stat.mode != MODE_IDLE) begin
							state_d = ST_STAT_REJ;
						end else begin
							ctl.set_wr = 1'b1;
							state_d = ST_START;
						end
					end
					CMD_RD_BEGIN: begin
						if ((stat.mode != MODE_IDLE) || !stat.len_ok) begin
							state_d = ST_STAT_REJ;
						end else begin
							ctl.set_rd = 1'b1;
							state_d = ST_START;
						end
					end
					CMD_WR_BYTE: begin
						if (stat.mode == MODE_WR) begin
							state_d = ST_WDATA;
						end
					end
					CMD_RX_BYTE: begin
						if (stat.mode == MODE_RD) begin
							ctl.rx_byte = 1'b1;
							state_d = stat.more_recv ? ST_RECV : ST_STOP;
						end
					end
					CMD_NACK: begin
						if ((stat.mode != MODE_IDLE) && !nack_ignored) begin
							state_d = ST_STOP;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_START: begin
				strobe = 1'b1;
				action = ACT_START;
				ctl.seed_waddr = (stat.cmd == CMD_WR_BEGIN);
				state_d = ST_SEND_WA;
			end
			ST_SEND_WA: begin
				strobe = 1'b1;
				action = ACT_SEND;
				ctl.val_sel = VAL_WADDR;
				state_d = ST_SEND_REG;
			end
			ST_SEND_REG: begin
				strobe = 1'b1;
				action = ACT_SEND;
				ctl.val_sel = VAL_REG;
				if (stat.cmd == CMD_WR_BEGIN) begin
					ctl.seed_reg = 1'b1;
					last = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_RESTART;
				end
			end
			ST_RESTART: begin
				strobe = 1'b1;
				action = ACT_START;
				state_d = ST_SEND_RA;
			end
			ST_SEND_RA: begin
				strobe = 1'b1;
				action = ACT_SEND;
				ctl.val_sel = VAL_RADDR;
				ctl.seed_raddr = 1'b1;
				state_d = ST_RECV;
			end
			ST_RECV: begin
				strobe = 1'b1;
				action = stat.recv_nack ? ACT_RECV_NACK : ACT_RECV_ACK;
				last = 1'b1;
				state_d = ST_IDLE;
			end
			ST_WDATA: begin
				strobe = 1'b1;
				action = ACT_SEND;
				ctl.val_sel = VAL_DATA;
				ctl.wr_byte = 1'b1;
				if (stat.crc_on) begin
					state_d = ST_WCRC;
				end else if (stat.lastb) begin
					state_d = ST_STOP;
				end else begin
					last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_WCRC: begin
				strobe = 1'b1;
				action = ACT_SEND;
				ctl.val_sel = VAL_CRC;
				if (stat.lastb) begin
					state_d = ST_STOP;
				end else begin
					last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_STOP: begin
				strobe = 1'b1;
				action = ACT_STOP;
				case (stat.cmd)
					CMD_WR_BYTE: state_d = ST_STAT_OK;
					CMD_RX_BYTE: begin
						if (stat.crc_on && stat.crc_bad) begin
							state_d = ST_STAT_CRC;
						end else begin
							ctl.rd_first = 1'b1;
							state_d = ST_DATA;
						end
					end
					default: state_d = ST_STAT_NACK;
				endcase
			end
			ST_DATA: begin
				strobe = 1'b1;
				action = ACT_DATA;
				ctl.val_sel = VAL_RBUF;
				ctl.rd_next = 1'b1;
				if (stat.data_last) begin
					state_d = ST_STAT_OK;
				end
			end
			ST_STAT_OK: begin
				strobe = 1'b1;
				action = ACT_STATUS;
				status = STS_OK;
				ctl.go_idle = 1'b1;
				last = 1'b1;
				state_d = ST_IDLE;
			end
			ST_STAT_NACK: begin
				strobe = 1'b1;
				action = ACT_STATUS;
				status = STS_NACK;
				ctl.go_idle = 1'b1;
				last = 1'b1;
				state_d = ST_IDLE;
			end
			ST_STAT_CRC: begin
				strobe = 1'b1;
				action = ACT_STATUS;
				status = STS_CRC;
				ctl.go_idle = 1'b1;
				last = 1'b1;
				state_d = ST_IDLE;
			end
			ST_STAT_REJ: begin
				strobe = 1'b1;
				action = ACT_STATUS;
				status = STS_REJ;
				last = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`IC8_ASSERT_NOW(a_strobe_busy, strobe, busy, "result beat while the sequencer is idle")
	`IC8_ASSERT_NEXT(a_accept_decode, start && !busy, (state_q == ST_DECODE) && !strobe, "accepted item not decoded")
	`IC8_ASSERT_NOW(a_last_strobe, last, strobe, "last flag without a result beat")
	`IC8_ASSERT_NEXT(a_final_idle, strobe && last, !busy, "sequencer still busy after the final beat")

endmodule

### tb/ic8_tb_pkg.sv
// Scoreboard class for the I2C CRC-8 transfer sequencer testbench: it predicts the result
// beats of every accepted command beat and checks the observed result beats against them.
// Depends on ic8_pkg for the command, action, status and mode codes.
`timescale 1ns / 1ps

package ic8_tb_pkg;
	import ic8_pkg::*;

	class ic8_transfer_scoreboard;
		typedef struct packed {
			act_t       action;
			logic [7:0] value;
			sts_t       status;
			logic       last;
		} result_beat_t;

		bit           crc_on;
		mode_t        mode;
		logic [7:0]   first_seed;
		logic [5:0]   byte_cnt;
		logic [4:0]   rd_len;
		logic [7:0]   held_byte;
		bit           crc_fail;
		logic [7:0]   rd_buf [MAX_READ_LEN];
		result_beat_t beats_due [$];
		result_beat_t staged;
		bit           have_staged;
		int           errors;

		function new();
			crc_on = 1'b1;
			mode = MODE_IDLE;
			first_seed = 8'h00;
			byte_cnt = '0;
			rd_len = '0;
			held_byte = 8'h00;
			crc_fail = 1'b0;
			have_staged = 1'b0;
			errors = 0;
			foreach (rd_buf[i]) rd_buf[i] = 8'h00;
		endfunction

		// Bit-serial CRC-8, MSB first: each message bit is folded into the feedback.
		static function logic [7:0] crc8_step(logic [7:0] acc, logic [7:0] b);
			logic [7:0] r;
			logic       fb;
			r = acc;
			for (int i = 7; i >= 0; i--) begin
				fb = r[7] ^ b[i];
				r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
			end
			return r;
		endfunction

		function void set_crc_on(bit v);
			crc_on = v;
		endfunction

		function int pending();
			return beats_due.size();
		endfunction

		// The newest beat is held back so that the final one of a command can be marked last.
		function void emit(act_t a, logic [7:0] v, sts_t s);
			if (have_staged) beats_due.push_back(staged);
			staged.action = a;
			staged.value = v;
			staged.status = s;
			staged.last = 1'b0;
			have_staged = 1'b1;
		endfunction

		function void note_command(logic [2:0] c, logic [6:0] dev, logic [7:0] ra,
				logic [7:0] d, logic [4:0] len, logic lastb);
			logic [7:0] waddr;
			logic [7:0] raddr;
			int         total;
			waddr = {dev, 1'b0};
			raddr = {dev, 1'b1};
			total = crc_on ? 2 * rd_len : rd_len;
			case (c)
				CMD_WR_BEGIN: begin
					if (mode != MODE_IDLE) begin
						emit(ACT_STATUS, 8'h00, STS_REJ);
					end else begin
						mode = MODE_WR;
						byte_cnt = '0;
						first_seed = crc8_step(crc8_step(8'h00, waddr), ra);
						emit(ACT_START, 8'h00, STS_OK);
						emit(ACT_SEND, waddr, STS_OK);
						emit(ACT_SEND, ra, STS_OK);
					end
				end
				CMD_RD_BEGIN: begin
					if (mode != MODE_IDLE || len == 0 || len > MAX_READ_LEN) begin
						emit(ACT_STATUS, 8'h00, STS_REJ);
					end else begin
						total = crc_on ? 2 * len : len;
						mode = MODE_RD;
						rd_len = len;
						byte_cnt = '0;
						crc_fail = 1'b0;
						held_byte = 8'h00;
						first_seed = crc8_step(8'h00, raddr);
						emit(ACT_START, 8'h00, STS_OK);
						emit(ACT_SEND, waddr, STS_OK);
						emit(ACT_SEND, ra, STS_OK);
						emit(ACT_START, 8'h00, STS_OK);
						emit(ACT_SEND, raddr, STS_OK);
						emit(total <= 1 ? ACT_RECV_NACK : ACT_RECV_ACK, 8'h00, STS_OK);
					end
				end
				CMD_WR_BYTE: begin
					if (mode == MODE_WR) begin
						emit(ACT_SEND, d, STS_OK);
						if (crc_on)
							emit(ACT_SEND, crc8_step(byte_cnt == 0 ? first_seed : 8'h00, d),
								STS_OK);
						if (byte_cnt < 6'd63) byte_cnt++;
						if (lastb) begin
							emit(ACT_STOP, 8'h00, STS_OK);
							emit(ACT_STATUS, 8'h00, STS_OK);
							mode = MODE_IDLE;
						end
					end
				end
				CMD_RX_BYTE: begin
					if (mode == MODE_RD) begin
						if (crc_on) begin
							if (!byte_cnt[0]) begin
								held_byte = d;
								if ((byte_cnt >> 1) < MAX_READ_LEN) rd_buf[byte_cnt >> 1] = d;
							end else if (crc8_step(byte_cnt == 1 ? first_seed : 8'h00,
									held_byte) != d) begin
								crc_fail = 1'b1;
							end
						end else if (byte_cnt < MAX_READ_LEN) begin
							rd_buf[byte_cnt] = d;
						end
						if (byte_cnt < 6'd63) byte_cnt++;
						if (byte_cnt < total) begin
							emit(byte_cnt + 1 == total ? ACT_RECV_NACK : ACT_RECV_ACK,
								8'h00, STS_OK);
						end else begin
							emit(ACT_STOP, 8'h00, STS_OK);
							if (crc_on && crc_fail) begin
								emit(ACT_STATUS, 8'h00, STS_CRC);
							end else begin
								for (int k = 0; k < rd_len && k < MAX_READ_LEN; k++)
									emit(ACT_DATA, rd_buf[k], STS_OK);
								emit(ACT_STATUS, 8'h00, STS_OK);
							end
							mode = MODE_IDLE;
						end
					end
				end
				CMD_NACK: begin
					if (mode == MODE_WR || mode == MODE_RD) begin
						// With CRC framing, nacks are ignored during reads and before the
						// first data byte of a write.
						if (!(crc_on && mode == MODE_RD) &&
								!(crc_on && mode == MODE_WR && byte_cnt == 0)) begin
							emit(ACT_STOP, 8'h00, STS_OK);
							emit(ACT_STATUS, 8'h00, STS_NACK);
							mode = MODE_IDLE;
						end
					end
				end
				default: begin
				end
			endcase
			if (have_staged) begin
				staged.last = 1'b1;
				beats_due.push_back(staged);
				have_staged = 1'b0;
			end
		endfunction

		function void complain(string what, logic [7:0] want, logic [7:0] got);
			errors++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
		endfunction

		function void check_result(logic [2:0] a, logic [7:0] v, logic [1:0] s, logic l);
			result_beat_t want;
			if (beats_due.size() == 0) begin
				errors++;
				$display("%0t ns: result beat with none expected, actual %0d %0h %0d %0b",
					$time, a, v, s, l);
				return;
			end
			want = beats_due.pop_front();
			if (a !== want.action) complain("action", want.action, a);
			if (v !== want.value) complain("value", want.value, v);
			if (s !== want.status) complain("status", want.status, s);
			if (l !== want.last) complain("last", want.last, l);
		endfunction
	endclass

endpackage

### tb/tb_i2c_crc8_framed_transfer.sv
// Self-checking testbench of the I2C CRC-8 transfer sequencer: directed and random command
// streams with random gaps, checked beat by beat against the scoreboard in ic8_tb_pkg.
// Depends on ic8_pkg, ic8_tb_pkg and the i2c_crc8_framed_transfer RTL.
`timescale 1ns / 1ps

module tb_i2c_crc8_framed_transfer;
	import ic8_pkg::*;
	import ic8_tb_pkg::*;

	// Command codes that the block must ignore.
	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	// Far above the slowest correct run of a few hundred commands.
	localparam int CYCLE_LIMIT = 200_000;
	// Cycles left after the last expected beat, covering a command still in decode.
	localparam int SETTLE_CYCLES = 24;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [2:0] cmd;
	logic [6:0] dev_addr;
	logic [7:0] reg_addr;
	logic [7:0] data;
	logic [4:0] read_len;
	logic       last_byte;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       cfg_data;
	logic       strobe;
	logic [2:0] action;
	logic [7:0] value;
	logic [1:0] status;
	logic       last;

	ic8_transfer_scoreboard sb;
	int items_sent;
	// Remaining command beats of a stretch that is sent back to back.
	int burst_left;

	i2c_crc8_framed_transfer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.dev_addr  (dev_addr),
		.reg_addr  (reg_addr),
		.data      (data),
		.read_len  (read_len),
		.last_byte (last_byte),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.strobe    (strobe),
		.action    (action),
		.value     (value),
		.status    (status),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// All sampling happens here, at the rising edge, before the block's registers move.
	// A configuration write updates the predicted crc_on at the edge that takes it, and a
	// command beat is predicted at the edge where start is high and busy is low.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) sb.set_crc_on(cfg_data);
			if (strobe) sb.check_result(action, value, status, last);
			if (start && !busy)
				sb.note_command(cmd, dev_addr, reg_addr, data, read_len, last_byte);
		end
	end

	// Watchdog: a hung handshake or a missing result ends the run here.
	initial begin
		for (int cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Bytes lean toward the two extremes so that both show up often.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Sends one command beat. It is called at a falling edge and returns at a falling edge
	// after the beat has been taken and the sender's own gap has passed. With a gap of zero,
	// start stays high so that the next call can put its beat right behind this one.
	task automatic issue(logic [2:0] c, logic [6:0] dev, logic [7:0] ra, logic [7:0] d,
			logic [4:0] len, logic lb);
		int gap;
		cmd = c;
		dev_addr = dev;
		reg_addr = ra;
		data = d;
		read_len = len;
		last_byte = lb;
		start = 1'b1;
		do begin
			@(posedge clk);
		end while (busy);
		@(negedge clk);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else begin
			gap = $urandom_range(0, 7);
			if ($urandom_range(0, 11) == 0) burst_left = $urandom_range(4, 16);
		end
		if (gap > 0) begin
			// The fields carry junk while start is low; the block must not look at them.
			start = 1'b0;
			cmd = 3'($urandom);
			dev_addr = 7'($urandom);
			reg_addr = 8'($urandom);
			data = 8'($urandom);
			read_len = 5'($urandom);
			last_byte = 1'($urandom);
			repeat (gap) @(negedge clk);
		end
	endtask

	// Finishes whatever transfer is open: a write gets a final byte, a read gets bus bytes
	// until it completes, most likely with a CRC mismatch when framing is on.
	task automatic close_transfer();
		while (sb.mode == MODE_WR)
			issue(CMD_WR_BYTE, 7'($urandom), pick_byte(), pick_byte(), 5'($urandom), 1'b1);
		while (sb.mode == MODE_RD)
			issue(CMD_RX_BYTE, 7'($urandom), pick_byte(), pick_byte(), 5'($urandom),
				1'($urandom));
	endtask

	// Writes crc_on once no transfer is open and every expected beat has come out.
	task automatic set_crc(bit v);
		close_transfer();
		start = 1'b0;
		while (sb.pending() > 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_data = v;
		cfg_valid = 1'b1;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_data = 1'($urandom);
	endtask

	// Random traffic: mostly well-formed block writes and reads with random content, the
	// rest single commands of any code and field values. A phase may start with one very
	// long write block, which drives the byte counter into saturation.
	task automatic run_phase(int count, bit long_block);
		int         stop_at;
		int         pick;
		int         len;
		logic [6:0] dev;
		logic [7:0] ra;
		logic [7:0] d;
		logic [7:0] chk;
		logic [7:0] seed;
		stop_at = items_sent + count;
		if (long_block) begin
			issue(CMD_WR_BEGIN, 7'($urandom), pick_byte(), pick_byte(), 5'($urandom), 1'b0);
			for (int i = 0; i < 66; i++)
				issue(CMD_WR_BYTE, 7'($urandom), pick_byte(), pick_byte(), 5'($urandom),
					i == 65);
		end
		while (items_sent < stop_at) begin
			dev = 7'(pick_byte());
			ra = pick_byte();
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				issue(CMD_WR_BEGIN, dev, ra, pick_byte(), 5'($urandom), 1'($urandom));
				len = $urandom_range(1, 5);
				for (int i = 0; i < len && sb.mode == MODE_WR; i++) begin
					if ($urandom_range(0, 11) == 0)
						issue(CMD_NACK, dev, ra, pick_byte(), 5'($urandom), 1'($urandom));
					else
						issue(CMD_WR_BYTE, 7'($urandom), pick_byte(), pick_byte(),
							5'($urandom), i == len - 1);
				end
			end else if (pick < 85) begin
				// Mostly short reads keep the run fast; now and then the full depth.
				case ($urandom_range(0, 9))
					0: len = MAX_READ_LEN;
					1: len = $urandom_range(1, MAX_READ_LEN);
					default: len = $urandom_range(1, 3);
				endcase
				issue(CMD_RD_BEGIN, dev, ra, pick_byte(), 5'(len), 1'($urandom));
				seed = ic8_transfer_scoreboard::crc8_step(8'h00, {dev, 1'b1});
				for (int i = 0; i < len && sb.mode == MODE_RD; i++) begin
					d = pick_byte();
					// A nack here is ignored with framing on and aborts the read without.
					if ($urandom_range(0, 15) == 0)
						issue(CMD_NACK, dev, ra, pick_byte(), 5'($urandom), 1'($urandom));
					issue(CMD_RX_BYTE, 7'($urandom), pick_byte(), d, 5'($urandom),
						1'($urandom));
					if (sb.crc_on && sb.mode == MODE_RD) begin
						chk = ic8_transfer_scoreboard::crc8_step(i == 0 ? seed : 8'h00, d);
						// One CRC byte in eight is corrupted in a single bit.
						if ($urandom_range(0, 7) == 0) chk ^= 8'(1 << $urandom_range(0, 7));
						issue(CMD_RX_BYTE, 7'($urandom), pick_byte(), chk, 5'($urandom),
							1'($urandom));
					end
				end
			end else begin
				issue(3'($urandom), 7'($urandom), pick_byte(), pick_byte(), 5'($urandom),
					1'($urandom));
			end
			// Leaving a transfer open now and then lets the next begin be rejected.
			if (sb.mode != MODE_IDLE && $urandom_range(0, 3) != 0) close_transfer();
		end
	endtask

	initial begin
		int guard;
		sb = new();
		items_sent = 0;
		burst_left = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_WR_BEGIN;
		dev_addr = 7'h00;
		reg_addr = 8'h00;
		data = 8'h00;
		read_len = 5'd0;
		last_byte = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, with CRC framing on as after reset.
		// A write block at the address extremes. The nack before the first data byte is
		// ignored, and begin commands during the open write are rejected.
		issue(CMD_WR_BEGIN, 7'h7F, 8'hFF, 8'h00, 5'd0, 1'b0);
		issue(CMD_NACK, 7'h00, 8'h00, 8'h00, 5'd0, 1'b0);
		issue(CMD_WR_BYTE, 7'h00, 8'h00, 8'h00, 5'd0, 1'b0);
		issue(CMD_WR_BEGIN, 7'h00, 8'h00, 8'h00, 5'd0, 1'b0);
		issue(CMD_RD_BEGIN, 7'h00, 8'h00, 8'h00, 5'd1, 1'b0);
		issue(CMD_WR_BYTE, 7'h7F, 8'hFF, 8'hFF, 5'd31, 1'b1);
		// A one-pair read with a good CRC; the nack in the middle is ignored.
		issue(CMD_RD_BEGIN, 7'h00, 8'h00, 8'h00, 5'd1, 1'b0);
		issue(CMD_RX_BYTE, 7'h00, 8'h00, 8'hA5, 5'd0, 1'b0);
		issue(CMD_NACK, 7'h00, 8'h00, 8'h00, 5'd0, 1'b0);
		issue(CMD_RX_BYTE, 7'h00, 8'h00, ic8_transfer_scoreboard::crc8_step(
			ic8_transfer_scoreboard::crc8_step(8'h00, 8'h01), 8'hA5), 5'd0, 1'b0);
		// A one-pair read whose CRC byte is wrong.
		issue(CMD_RD_BEGIN, 7'h7F, 8'hFF, 8'h00, 5'd1, 1'b1);
		issue(CMD_RX_BYTE, 7'h00, 8'h00, 8'hFF, 5'd0, 1'b0);
		issue(CMD_RX_BYTE, 7'h00, 8'h00, ~ic8_transfer_scoreboard::crc8_step(
			ic8_transfer_scoreboard::crc8_step(8'h00, 8'hFF), 8'hFF), 5'd0, 1'b0);
		// Read lengths out of range: zero, one past the depth, and the largest code.
		issue(CMD_RD_BEGIN, 7'h11, 8'h22, 8'h00, 5'd0, 1'b0);
		issue(CMD_RD_BEGIN, 7'h11, 8'h22, 8'h00, 5'(MAX_READ_LEN + 1), 1'b0);
		issue(CMD_RD_BEGIN, 7'h11, 8'h22, 8'h00, 5'd31, 1'b0);
		// A write aborted by a nack after its first data byte.
		issue(CMD_WR_BEGIN, 7'h2A, 8'h55, 8'h00, 5'd0, 1'b0);
		issue(CMD_WR_BYTE, 7'h00, 8'h00, 8'h3C, 5'd0, 1'b0);
		issue(CMD_NACK, 7'h00, 8'h00, 8'h00, 5'd0, 1'b0);
		// Commands out of place while idle, and unused codes: all without effect.
		issue(CMD_WR_BYTE, 7'h00, 8'h00, 8'h12, 5'd0, 1'b1);
		issue(CMD_RX_BYTE, 7'h00, 8'h00, 8'h34, 5'd0, 1'b0);
		issue(CMD_NACK, 7'h00, 8'h00, 8'h00, 5'd0, 1'b0);
		issue(CMD_SPARE_LO, 7'h7F, 8'hFF, 8'hFF, 5'd16, 1'b1);
		issue(CMD_SPARE_HI, 7'h7F, 8'hFF, 8'hFF, 5'd16, 1'b1);

		// Random part, alternating plain transfers and CRC framing.
		run_phase(60, 1'b0);
		set_crc(1'b0);
		run_phase(60, 1'b0);
		set_crc(1'b1);
		run_phase(60, 1'b1);
		set_crc(1'b0);
		run_phase(60, 1'b0);
		close_transfer();
		start = 1'b0;

		for (guard = 0; guard < 5000 && sb.pending() > 0; guard++) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sb.pending() > 0)
			$display("%0t ns: %0d expected result beats never came out", $time, sb.pending());
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

### i2c_crc8_framed_transfer.f
+incdir+hdl
hdl/ic8_pkg.sv
hdl/ic8_datapath.sv
hdl/ic8_ctrl.sv
hdl/i2c_crc8_framed_transfer.sv
tb/ic8_tb_pkg.sv
tb/tb_i2c_crc8_framed_transfer.sv
